[design/assert_macros.svh]
// Assertion helpers used by the hash table core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define CHT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CHT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/cht_pkg.sv]
package cht_pkg;

    // table geometry and field widths
    localparam int SLOTS_DEFAULT = 8;
    localparam int VALUE_W       = 31;
    localparam int STATUS_W      = 2;
    localparam int SLOT_FIELD_W  = 3;
    localparam int IN_TDATA_W    = 32;
    localparam int OUT_TDATA_W   = 8;

    // command codes carried on s_tuser
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    // result status codes carried on m_tuser
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    // write strobes from the sequencer to the slot store
    typedef struct packed {
        logic value_we;
        logic link_we;
        logic used_we;
        logic used_clr;
    } cht_wr_ctl_t;

endpackage

[design/cht_home.sv]
module cht_home #(
    parameter int SLOTS = cht_pkg::SLOTS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [cht_pkg::VALUE_W-1:0]   value,
    output logic                          done,
    output logic [$clog2(SLOTS)-1:0]      home
);
    import cht_pkg::*;

    localparam int IW     = $clog2(SLOTS);
    localparam int SH     = VALUE_W + IW;
    localparam int RCP_W  = 32;
    localparam int PROD_W = VALUE_W + RCP_W;
    localparam int Q_W    = PROD_W - SH;
    localparam int RW     = VALUE_W + 1;
    localparam logic [63:0]      RECIP_WIDE = (64'd1 << SH) / SLOTS;
    localparam logic [RCP_W-1:0] RECIP      = RECIP_WIDE[RCP_W-1:0];

    logic [PROD_W-1:0]  prod_reg;
    logic [VALUE_W-1:0] val_reg;
    logic               stage1_reg;
    logic               done_reg;
    logic [IW-1:0]      home_reg;

    logic [Q_W-1:0] quot;
    logic [RW-1:0]  back;
    logic [RW-1:0]  rem_raw;
    logic [RW-1:0]  rem_fix;

    // stage 1: multiply by the truncated reciprocal
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= PROD_W'(value) * PROD_W'(RECIP);
            val_reg  <= value;
        end
    end

    // stage 2: remainder, quotient is low by at most one
    always_comb
    begin
        quot    = prod_reg[PROD_W-1:SH];
        back    = RW'(quot) * RW'(SLOTS);
        rem_raw = {1'b0, val_reg} - back;
        rem_fix = (rem_raw >= RW'(SLOTS)) ? (rem_raw - RW'(SLOTS)) : rem_raw;
    end

    always_ff @(posedge clk)
    begin
        if (stage1_reg)
            home_reg <= rem_fix[IW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage1_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            stage1_reg <= start;
            done_reg   <= stage1_reg;
        end
    end

    assign done = done_reg;
    assign home = home_reg;

endmodule

[design/cht_store.sv]
module cht_store #(
    parameter int SLOTS = cht_pkg::SLOTS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [$clog2(SLOTS)-1:0]       rd_addr,
    output logic [cht_pkg::VALUE_W-1:0]    rd_value,
    output logic [$clog2(SLOTS+1)-1:0]     rd_link,
    output logic                           rd_used,
    input  cht_pkg::cht_wr_ctl_t           ctl,
    input  logic [$clog2(SLOTS)-1:0]       val_addr,
    input  logic [cht_pkg::VALUE_W-1:0]    val_data,
    input  logic                           used_data,
    input  logic [$clog2(SLOTS)-1:0]       link_addr,
    input  logic [$clog2(SLOTS+1)-1:0]     link_data,
    input  logic [$clog2(SLOTS)-1:0]       clr_addr,
    output logic [SLOTS-1:0]               used_bits
);
    import cht_pkg::*;

    localparam int LW = $clog2(SLOTS + 1);
    localparam logic [LW-1:0] LINK_NULL = LW'(SLOTS);

    logic [VALUE_W-1:0] value_mem [SLOTS];
    logic [LW-1:0]      link_mem  [SLOTS];
    logic [VALUE_W-1:0] value_q;
    logic [LW-1:0]      link_q;
    logic               used_q;
    logic [SLOTS-1:0]   used_reg;
    logic [SLOTS-1:0]   used_next;

    // key and link memories, one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (ctl.value_we)
            value_mem[val_addr] <= val_data;
        if (ctl.link_we)
            link_mem[link_addr] <= link_data;
        value_q <= value_mem[rd_addr];
        link_q  <= link_mem[rd_addr];
    end

    // occupancy flags, also the valid bits of the memories
    always_comb
    begin
        used_next = used_reg;
        if (ctl.used_clr)
            used_next[clr_addr] = 1'b0;
        if (ctl.used_we)
            used_next[val_addr] = used_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            used_q   <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
            used_q   <= used_reg[rd_addr];
        end
    end

    // a free slot reads as empty: key zero, no successor
    assign rd_used   = used_q;
    assign rd_value  = used_q ? value_q : '0;
    assign rd_link   = used_q ? link_q : LINK_NULL;
    assign used_bits = used_reg;

endmodule

[design/coalesced_hash_table_core.sv]
// Coalesced-chaining hash table of SLOTS slots. Each item is an insert or a
// delete of a 31-bit key and gives exactly one result item with a status and
// the slot written or freed. The block handles one item at a time and is not
// ready while it works. Every item first reduces the key to its home slot
// (a two-stage reciprocal multiply), then visits one chain slot per cycle
// through the single read port of the slot memory, then returns to idle. An
// insert to a free home slot writes it directly; an insert behind a chain
// walks the chain, then does a one-slot-per-cycle search for a free slot,
// then writes the tail link; a delete scans the chain and may fetch the
// head's successor. A finished result waits in an output register and the
// next item is taken in the cycle that result is taken. There is no clearing
// pass after reset.
`include "assert_macros.svh"

module coalesced_hash_table_core #(
    parameter int SLOTS = cht_pkg::SLOTS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cht_pkg::IN_TDATA_W-1:0]    s_tdata,   // [30:0] value
    input  logic [0:0]                        s_tuser,   // [0] command
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cht_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [2:0] slot
    output logic [cht_pkg::STATUS_W-1:0]      m_tuser    // [1:0] status
);
    import cht_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int LW = $clog2(SLOTS + 1);
    localparam logic [LW-1:0] LINK_NULL = LW'(SLOTS);
    localparam logic [IW-1:0] LAST_STEP = IW'(SLOTS - 1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_HOME     = 3'd1;
    localparam logic [2:0] S_ITAIL    = 3'd2;
    localparam logic [2:0] S_PROBE    = 3'd3;
    localparam logic [2:0] S_ITAIL_WR = 3'd4;
    localparam logic [2:0] S_DSCAN    = 3'd5;
    localparam logic [2:0] S_DSUCC    = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic                cmd_reg, cmd_next;
    logic [VALUE_W-1:0]  value_reg, value_next;
    logic [IW-1:0]       cur_reg, cur_next;
    logic [IW-1:0]       prev_reg, prev_next;
    logic                prev_valid_reg, prev_valid_next;
    logic [IW-1:0]       pos_reg, pos_next;
    logic [IW-1:0]       step_reg, step_next;
    logic [LW-1:0]       fill_count_reg, fill_count_next;
    logic                m_tvalid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [IW-1:0]       slot_reg;

    logic                accept;
    logic                home_done;
    logic [IW-1:0]       home;
    logic [IW-1:0]       rd_addr;
    logic [VALUE_W-1:0]  rd_value;
    logic [LW-1:0]       rd_link;
    logic                rd_used;
    cht_wr_ctl_t         ctl;
    logic [IW-1:0]       val_addr;
    logic [VALUE_W-1:0]  val_data;
    logic                used_data;
    logic [IW-1:0]       link_addr;
    logic [LW-1:0]       link_data;
    logic [IW-1:0]       clr_addr;
    logic [SLOTS-1:0]    used_bits;

    logic                link_null;
    logic [IW-1:0]       link_idx;
    logic [LW-1:0]       link_clean;
    logic                key_match;
    logic [IW-1:0]       home_inc;
    logic [IW-1:0]       pos_inc;
    logic [LW-1:0]       fill_dec;
    logic                result_fire;
    logic [STATUS_W-1:0] result_status;
    logic [IW-1:0]       result_slot;
    logic                out_miss;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE) && (!m_tvalid_reg || m_tready);

    cht_home #(
        .SLOTS (SLOTS)
    ) u_home (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .value (s_tdata[VALUE_W-1:0]),
        .done  (home_done),
        .home  (home)
    );

    cht_store #(
        .SLOTS (SLOTS)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_addr   (rd_addr),
        .rd_value  (rd_value),
        .rd_link   (rd_link),
        .rd_used   (rd_used),
        .ctl       (ctl),
        .val_addr  (val_addr),
        .val_data  (val_data),
        .used_data (used_data),
        .link_addr (link_addr),
        .link_data (link_data),
        .clr_addr  (clr_addr),
        .used_bits (used_bits)
    );

    // decode of the slot just read; an out-of-range link means end of chain
    always_comb
    begin
        link_null  = rd_link >= LINK_NULL;
        link_idx   = rd_link[IW-1:0];
        link_clean = link_null ? LINK_NULL : rd_link;
        key_match  = rd_used && (rd_value == value_reg);
        home_inc   = (home == LAST_STEP) ? '0 : home + IW'(1);
        pos_inc    = (pos_reg == LAST_STEP) ? '0 : pos_reg + IW'(1);
        fill_dec   = (fill_count_reg != '0) ? fill_count_reg - LW'(1) : fill_count_reg;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        value_next      = value_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        prev_valid_next = prev_valid_reg;
        pos_next        = pos_reg;
        step_next       = step_reg;
        fill_count_next = fill_count_reg;
        rd_addr         = cur_reg;
        ctl             = '0;
        val_addr        = cur_reg;
        val_data        = value_reg;
        used_data       = 1'b1;
        link_addr       = cur_reg;
        link_data       = LINK_NULL;
        clr_addr        = cur_reg;
        result_fire     = 1'b0;
        result_status   = ST_INSERTED;
        result_slot     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = s_tuser[0];
                    value_next = s_tdata[VALUE_W-1:0];
                    state_next = S_HOME;
                end
            end

            S_HOME:
            begin
                if (home_done)
                begin
                    cur_next        = home;
                    pos_next        = home_inc;
                    step_next       = '0;
                    prev_valid_next = 1'b0;
                    rd_addr         = home;
                    if (cmd_reg == CMD_DELETE)
                        state_next = S_DSCAN;
                    else if (fill_count_reg >= LINK_NULL)
                    begin
                        result_fire   = 1'b1;
                        result_status = ST_FULL;
                        state_next    = S_IDLE;
                    end
                    else if (!used_bits[home])
                    begin
                        // home slot free: store directly
                        ctl.value_we    = 1'b1;
                        ctl.link_we     = 1'b1;
                        ctl.used_we     = 1'b1;
                        val_addr        = home;
                        link_addr       = home;
                        fill_count_next = fill_count_reg + LW'(1);
                        result_fire     = 1'b1;
                        result_status   = ST_INSERTED;
                        result_slot     = home;
                        state_next      = S_IDLE;
                    end
                    else
                        state_next = S_ITAIL;
                end
            end

            // follow links to the chain tail, one per cycle
            S_ITAIL:
            begin
                if (!link_null)
                    cur_next = link_idx;
                if (link_null || step_reg == LAST_STEP)
                begin
                    step_next  = '0;
                    state_next = S_PROBE;
                end
                else
                begin
                    step_next = step_reg + IW'(1);
                    rd_addr   = link_idx;
                end
            end

            // linear search for a free slot from home+1
            S_PROBE:
            begin
                if (!used_bits[pos_reg])
                begin
                    ctl.value_we    = 1'b1;
                    ctl.link_we     = 1'b1;
                    ctl.used_we     = 1'b1;
                    val_addr        = pos_reg;
                    link_addr       = pos_reg;
                    fill_count_next = fill_count_reg + LW'(1);
                    state_next      = S_ITAIL_WR;
                end
                else if (step_reg == LAST_STEP)
                begin
                    result_fire   = 1'b1;
                    result_status = ST_FULL;
                    state_next    = S_IDLE;
                end
                else
                begin
                    pos_next  = pos_inc;
                    step_next = step_reg + IW'(1);
                end
            end

            // hang the new slot behind the tail
            S_ITAIL_WR:
            begin
                ctl.link_we   = 1'b1;
                link_addr     = cur_reg;
                link_data     = LW'(pos_reg);
                result_fire   = 1'b1;
                result_status = ST_INSERTED;
                result_slot   = pos_reg;
                state_next    = S_IDLE;
            end

            S_DSCAN:
            begin
                if (key_match && prev_valid_reg)
                begin
                    // inner match: unlink from predecessor
                    ctl.link_we     = 1'b1;
                    ctl.used_clr    = 1'b1;
                    link_addr       = prev_reg;
                    link_data       = link_clean;
                    fill_count_next = fill_dec;
                    result_fire     = 1'b1;
                    result_status   = ST_DELETED;
                    result_slot     = cur_reg;
                    state_next      = S_IDLE;
                end
                else if (key_match && (link_null || link_idx == cur_reg))
                begin
                    // lone head: just free it
                    ctl.used_clr    = 1'b1;
                    fill_count_next = fill_dec;
                    result_fire     = 1'b1;
                    result_status   = ST_DELETED;
                    result_slot     = cur_reg;
                    state_next      = S_IDLE;
                end
                else if (key_match)
                begin
                    // head with successor: fetch successor
                    pos_next   = link_idx;
                    rd_addr    = link_idx;
                    state_next = S_DSUCC;
                end
                else if (link_null || step_reg == LAST_STEP)
                begin
                    result_fire   = 1'b1;
                    result_status = ST_NOT_FOUND;
                    state_next    = S_IDLE;
                end
                else
                begin
                    prev_next       = cur_reg;
                    prev_valid_next = 1'b1;
                    cur_next        = link_idx;
                    step_next       = step_reg + IW'(1);
                    rd_addr         = link_idx;
                end
            end

            // successor moves into the head, its slot is freed
            S_DSUCC:
            begin
                ctl.value_we    = 1'b1;
                ctl.link_we     = 1'b1;
                ctl.used_we     = 1'b1;
                ctl.used_clr    = 1'b1;
                val_data        = rd_value;
                used_data       = rd_used;
                link_data       = link_clean;
                clr_addr        = pos_reg;
                fill_count_next = fill_dec;
                result_fire     = 1'b1;
                result_status   = ST_DELETED;
                result_slot     = pos_reg;
                state_next      = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_count_reg <= '0;
            m_tvalid_reg   <= 1'b0;
            prev_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            prev_valid_reg <= prev_valid_next;
            if (result_fire)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // working registers and result payload
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        value_reg <= value_next;
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        pos_reg   <= pos_next;
        step_reg  <= step_next;
        if (result_fire)
        begin
            status_reg <= result_status;
            slot_reg   <= result_slot;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = OUT_TDATA_W'(SLOT_FIELD_W'(slot_reg));

    // result item that carries no slot
    assign out_miss = m_tvalid && (m_tuser == ST_FULL || m_tuser == ST_NOT_FOUND);

    `CHT_ASSERT(a_fill_matches_used, $countones(used_bits) == int'(fill_count_reg), "bad fill")
    `CHT_ASSERT(a_fill_bounded, fill_count_reg <= LINK_NULL, "fill count above table size")
    `CHT_ASSERT_NEXT(a_accept_frees_output, accept, !m_tvalid, "result pending after accept")
    `CHT_ASSERT(a_miss_slot_zero, out_miss |-> m_tdata == '0, "slot not zero on full or not found")

endmodule

[tb/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cht_pkg::*;

    localparam int NUM_SLOTS    = SLOTS_DEFAULT;
    localparam int NULL_LINK    = NUM_SLOTS;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 4 * NUM_SLOTS + 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 450;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [SLOT_FIELD_W-1:0] slot;
    } result_t;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [0:0]             s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]    m_tuser;

    // shadow of the slot store, updated as each item is accepted
    logic [VALUE_W-1:0] shadow_key  [NUM_SLOTS];
    bit                 shadow_used [NUM_SLOTS];
    int                 shadow_link [NUM_SLOTS];
    int                 shadow_fill;

    result_t pending_results[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int error_count    = 0;
    int cycle_count    = 0;

    coalesced_hash_table_core #(
        .SLOTS(NUM_SLOTS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: long hold-off when asked, else random stalls
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result checker: oldest expectation first
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result item: status %0d slot %0d", m_tuser, m_tdata[2:0]);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    error_count++;
                end
                if (m_tdata[SLOT_FIELD_W-1:0] !== want.slot)
                begin
                    $error("slot: expected %0d, got %0d", want.slot,
                           m_tdata[SLOT_FIELD_W-1:0]);
                    error_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    function automatic void wipe_shadow();
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            shadow_key[i]  = '0;
            shadow_used[i] = 1'b0;
            shadow_link[i] = NULL_LINK;
        end
        shadow_fill = 0;
    endfunction

    function automatic int home_of(input logic [VALUE_W-1:0] key);
        return int'(key % NUM_SLOTS);
    endfunction

    // out-of-range links count as the end of a chain
    function automatic int next_slot(input int s);
        int n;
        n = shadow_link[s % NUM_SLOTS];
        return (n >= 0 && n < NUM_SLOTS) ? n : NULL_LINK;
    endfunction

    function automatic void occupy(input int s, input logic [VALUE_W-1:0] key);
        shadow_used[s] = 1'b1;
        shadow_key[s]  = key;
        shadow_link[s] = NULL_LINK;
        shadow_fill++;
    endfunction

    function automatic void vacate(input int s);
        shadow_used[s] = 1'b0;
        shadow_key[s]  = '0;
        shadow_link[s] = NULL_LINK;
    endfunction

    function automatic result_t chain_insert(input logic [VALUE_W-1:0] key);
        result_t r;
        int      home;
        int      tail;
        int      pos;
        r.status = ST_FULL;
        r.slot   = '0;
        home     = home_of(key);
        if (shadow_fill >= NUM_SLOTS)
            return r;
        if (!shadow_used[home])
        begin
            occupy(home, key);
            r.status = ST_INSERTED;
            r.slot   = SLOT_FIELD_W'(home);
            return r;
        end
        // walk to the chain tail, bounded in case of a loop
        tail = home;
        for (int k = 0; k < NUM_SLOTS; k++)
        begin
            if (next_slot(tail) == NULL_LINK)
                break;
            tail = next_slot(tail);
        end
        // linear probe from the slot after home
        pos = (home + 1) % NUM_SLOTS;
        for (int k = 0; k < NUM_SLOTS && shadow_used[pos]; k++)
            pos = (pos + 1) % NUM_SLOTS;
        if (shadow_used[pos])
            return r;
        occupy(pos, key);
        shadow_link[tail] = pos;
        r.status = ST_INSERTED;
        r.slot   = SLOT_FIELD_W'(pos);
        return r;
    endfunction

    function automatic result_t chain_delete(input logic [VALUE_W-1:0] key);
        result_t r;
        int      cur;
        int      prev;
        int      succ;
        bit      found;
        r.status = ST_NOT_FOUND;
        r.slot   = '0;
        cur      = home_of(key);
        prev     = NULL_LINK;
        found    = 1'b0;
        for (int k = 0; k < NUM_SLOTS; k++)
        begin
            if (shadow_used[cur] && shadow_key[cur] == key)
            begin
                found = 1'b1;
                break;
            end
            if (next_slot(cur) == NULL_LINK)
                break;
            prev = cur;
            cur  = next_slot(cur);
        end
        if (!found)
            return r;
        if (prev == NULL_LINK)
        begin
            succ = next_slot(cur);
            if (succ == NULL_LINK || succ == cur)
            begin
                vacate(cur);
                r.slot = SLOT_FIELD_W'(cur);
            end
            else
            begin
                // head takes over its successor
                shadow_key[cur]  = shadow_key[succ];
                shadow_used[cur] = shadow_used[succ];
                shadow_link[cur] = next_slot(succ);
                vacate(succ);
                r.slot = SLOT_FIELD_W'(succ);
            end
        end
        else
        begin
            shadow_link[prev] = next_slot(cur);
            vacate(cur);
            r.slot = SLOT_FIELD_W'(cur);
        end
        if (shadow_fill > 0)
            shadow_fill--;
        r.status = ST_DELETED;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // every stored key still reachable from its own home slot
    function automatic bit all_reachable();
        int  cur;
        bit  hit;
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            if (shadow_used[s])
            begin
                cur = home_of(shadow_key[s]);
                hit = 1'b0;
                for (int k = 0; k < NUM_SLOTS && cur != NULL_LINK; k++)
                begin
                    if (cur == s)
                        hit = 1'b1;
                    cur = next_slot(cur);
                end
                if (!hit)
                    return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // trial delete on the shadow, then put it back
    function automatic bit delete_keeps_reachable(input logic [VALUE_W-1:0] key);
        logic [VALUE_W-1:0] keep_key  [NUM_SLOTS];
        bit                 keep_used [NUM_SLOTS];
        int                 keep_link [NUM_SLOTS];
        int                 keep_fill;
        bit                 ok;
        keep_key  = shadow_key;
        keep_used = shadow_used;
        keep_link = shadow_link;
        keep_fill = shadow_fill;
        void'(chain_delete(key));
        ok = all_reachable();
        shadow_key  = keep_key;
        shadow_used = keep_used;
        shadow_link = keep_link;
        shadow_fill = keep_fill;
        return ok;
    endfunction

    function automatic bit pick_stored_key(input bit safe_only,
                                           output logic [VALUE_W-1:0] key);
        int start;
        int idx;
        key   = '0;
        start = $urandom_range(NUM_SLOTS - 1);
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            idx = (start + i) % NUM_SLOTS;
            if (shadow_used[idx] &&
                (!safe_only || delete_keeps_reachable(shadow_key[idx])))
            begin
                key = shadow_key[idx];
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic [VALUE_W-1:0] key_at_home(input int h);
        logic [VALUE_W-1:0] k;
        k = VALUE_W'($urandom);
        return VALUE_W'(k - (k % NUM_SLOTS) + VALUE_W'(h));
    endfunction

    function automatic void set_traffic(input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
    endfunction

    // offer one item, record its expected result on acceptance
    task automatic send_item(input logic cmd, input logic [VALUE_W-1:0] key);
        result_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - VALUE_W){1'b0}}, key};
        s_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_tready);
        if (cmd == CMD_INSERT)
            r = chain_insert(key);
        else
            r = chain_delete(key);
        pending_results.push_back(r);
    endtask

    // sender pauses until every result is back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // mixed traffic; leak_pct allows deletes that strand keys off their chain
    task automatic run_random(input int n, input int leak_pct);
        int                 ins_pct;
        int                 sel;
        bit                 found;
        logic               cmd;
        logic [VALUE_W-1:0] key;
        ins_pct = 50;
        for (int i = 0; i < n; i++)
        begin
            if (i % 32 == 0)
            begin
                case ($urandom_range(3))
                    0:       ins_pct = 30;
                    1:       ins_pct = 50;
                    2:       ins_pct = 65;
                    default: ins_pct = 85;
                endcase
            end
            cmd = ($urandom_range(99) < ins_pct) ? CMD_INSERT : CMD_DELETE;
            sel = $urandom_range(99);
            if (cmd == CMD_INSERT)
            begin
                if (sel < 50)
                begin
                    // crowd a few homes so chains run into each other
                    key = key_at_home($urandom_range(2));
                end
                else if (sel < 65)
                begin
                    found = pick_stored_key(1'b0, key);
                    if (!found)
                        key = key_at_home($urandom_range(NUM_SLOTS - 1));
                end
                else
                begin
                    key = key_at_home($urandom_range(NUM_SLOTS - 1));
                end
            end
            else
            begin
                if (sel < 70)
                begin
                    found = pick_stored_key($urandom_range(99) >= leak_pct, key);
                    if (!found)
                        key = key_at_home($urandom_range(NUM_SLOTS - 1));
                end
                else if (sel < 88)
                begin
                    key = key_at_home($urandom_range(NUM_SLOTS - 1));
                end
                else
                begin
                    key = VALUE_W'($urandom);
                end
            end
            send_item(cmd, key);
        end
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // absent delete, home hits, collisions, wrap-round probe, coalesced chains, full table
    task automatic test_insert_chains();
        set_traffic(0, 0);
        send_item(CMD_DELETE, 31'd5);
        send_item(CMD_INSERT, 31'd0);
        send_item(CMD_INSERT, 31'h7FFFFFFF);
        send_item(CMD_INSERT, 31'd8);
        send_item(CMD_INSERT, 31'd16);
        send_item(CMD_INSERT, 31'd8);
        send_item(CMD_INSERT, 31'h7FFFFFF7);
        send_item(CMD_INSERT, 31'd1);
        send_item(CMD_INSERT, 31'h55555555);
        send_item(CMD_INSERT, 31'h2AAAAAAA);
    endtask

    // absent key, tail and middle unlink, lone head, head taking over successor
    task automatic test_delete_cases();
        set_traffic(0, 0);
        send_item(CMD_DELETE, 31'h12345678);
        send_item(CMD_DELETE, 31'h55555555);
        send_item(CMD_DELETE, 31'd1);
        send_item(CMD_DELETE, 31'h7FFFFFF7);
        send_item(CMD_DELETE, 31'h7FFFFFFF);
        send_item(CMD_DELETE, 31'd16);
        send_item(CMD_DELETE, 31'd0);
        send_item(CMD_DELETE, 31'd8);
        send_item(CMD_DELETE, 31'd8);
        send_item(CMD_DELETE, 31'd8);
    endtask

    // fill to the brim, one insert too many, then empty again
    task automatic test_fill_and_empty();
        logic [VALUE_W-1:0] key;
        set_traffic(0, 0);
        while (shadow_fill < NUM_SLOTS)
            send_item(CMD_INSERT, key_at_home($urandom_range(NUM_SLOTS - 1)));
        send_item(CMD_INSERT, key_at_home($urandom_range(NUM_SLOTS - 1)));
        for (int i = 0; i < 2 * NUM_SLOTS; i++)
        begin
            if (!pick_stored_key(1'b1, key))
                break;
            send_item(CMD_DELETE, key);
        end
    endtask

    // receiver holds off while items keep coming, so the input stalls
    task automatic test_output_hold();
        set_traffic(0, 0);
        hold_left = HOLD_CYCLES;
        run_random(12, 0);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        set_traffic(0, 0);
        run_random(PHASE_ITEMS, 0);
        wait_idle();
        set_traffic(78, 0);
        run_random(PHASE_ITEMS, 0);
        wait_idle();
        set_traffic(0, 78);
        run_random(PHASE_ITEMS, 0);
        wait_idle();
        set_traffic(31, 31);
        run_random(PHASE_ITEMS, 5);
        wait_idle();
    endtask

    initial
    begin
        wipe_shadow();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_insert_chains();
        wait_idle();
        test_delete_cases();
        wait_idle();
        test_fill_and_empty();
        wait_idle();
        test_output_hold();
        test_random_traffic();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d result items never arrived", pending_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/cht_pkg.sv
design/cht_home.sv
design/cht_store.sv
design/coalesced_hash_table_core.sv
tb/tb_top.sv
